### rtl/acm_pkg.sv
// acm_pkg: shared types and constants of the multi-pattern byte matcher
// no dependencies; imported by the channel interfaces and every rtl module
`default_nettype none

package acm_pkg;

   localparam int unsigned SymW     = 8;
   localparam int unsigned DepthW   = 8;
   localparam int unsigned OutNodeW = 10;
   localparam int unsigned MatchW   = 9;
   localparam int unsigned StatusW  = 2;
   localparam int unsigned ActionW  = 2;

   typedef enum logic [ActionW-1:0] {
      ACT_ADD        = 2'd0,
      ACT_BUILD      = 2'd1,
      ACT_SCAN       = 2'd2,
      ACT_RESET_SCAN = 2'd3
   } action_type;

   typedef enum logic [StatusW-1:0] {
      ST_OK         = 2'd0,
      ST_NODE_FULL  = 2'd1,
      ST_PAT_FULL   = 2'd2,
      ST_UNUSED     = 2'd3
   } status_type;

   typedef enum logic [9:0] {
      S_CLEAR   = 10'b0000000001,
      S_IDLE    = 10'b0000000010,
      S_ADD_CHK = 10'b0000000100,
      S_F_CHK   = 10'b0000001000,
      S_F_FAIL  = 10'b0000010000,
      S_B_NODE  = 10'b0000100000,
      S_B_CHK   = 10'b0001000000,
      S_B_PAR   = 10'b0010000000,
      S_OUT     = 10'b0100000000,
      S_SPARE   = 10'b1000000000
   } state_type;

endpackage

`default_nettype wire

### rtl/acm_if.sv
// acm_if: valid/ready channel interfaces for request, response and csr beats
// depends on acm_pkg for field widths
`default_nettype none

interface acm_req_if import acm_pkg::*; ();
   logic               valid;
   logic               ready;
   logic [ActionW-1:0] action;
   logic [SymW-1:0]    data_byte;
   logic               last_byte;
   modport source (output valid, action, data_byte, last_byte, input ready);
   modport sink   (input valid, action, data_byte, last_byte, output ready);
endinterface

interface acm_rsp_if import acm_pkg::*; ();
   logic                valid;
   logic                ready;
   logic [OutNodeW-1:0] current_node;
   logic [MatchW-1:0]   match_id;
   logic [StatusW-1:0]  status;
   modport source (output valid, current_node, match_id, status, input ready);
   modport sink   (input valid, current_node, match_id, status, output ready);
endinterface

interface acm_csr_if import acm_pkg::*; ();
   logic valid;
   logic ready;
   logic strict_mode;
   modport source (output valid, strict_mode, input ready);
   modport sink   (input valid, strict_mode, output ready);
endinterface

`default_nettype wire

### rtl/aho_corasick_matcher.sv
// Byte matcher with a trie of NODES nodes and 256-way goto table in memory.
// After reset a clearing pass writes every goto entry, with no request
// taken. Scan follows fail-link hops on a goto miss, or in strict mode
// retries the byte from root; all lookups share the single goto-table
// read port. Build walks every allocated node but the root once per trie
// depth, and for each node below depth one at the current depth follows
// fail-link hops from its parent. A finished response waits in an output
// register and the next request may start meanwhile.
// depends on acm_pkg, acm_if, acm_child_ram
`default_nettype none

module aho_corasick_matcher import acm_pkg::*; #(
   parameter int unsigned NODES        = 1024,
   parameter int unsigned MAX_PATTERNS = 256,
   parameter int unsigned MAX_DEPTH    = 255
) (
   input wire logic clock,
   input wire logic reset,
   acm_req_if.sink    req_chan,
   acm_rsp_if.source  rsp_chan,
   acm_csr_if.sink    csr_chan
);

   localparam int unsigned NW  = $clog2(NODES);
   localparam int unsigned CAW = NW + SymW;
   localparam int unsigned PW  = $clog2(MAX_PATTERNS + 1);
   localparam logic [CAW:0]    CLR_LAST = (CAW+1)'(NODES * 256 - 1);
   localparam logic [NW:0]     NODE_TOP = (NW+1)'(NODES);
   localparam logic [PW-1:0]   PAT_TOP  = PW'(MAX_PATTERNS);
   localparam logic [DepthW:0] DEP_TOP  = (DepthW+1)'(MAX_DEPTH);

   state_type state_ff, state_in;
   logic [CAW:0]  clr_ff, clr_in;
   logic [NW:0]   nf_ff, nf_in;
   logic [PW-1:0] pcount_ff, pcount_in;
   logic [NW-1:0] cursor_ff, cursor_in;
   logic [NW-1:0] scan_ff, scan_in;
   logic          strict_ff, strict_in;
   logic [DepthW-1:0] maxdep_ff, maxdep_in;
   action_type    act_ff, act_in;
   logic [SymW-1:0] sym_ff, sym_in;
   logic          last_ff, last_in;
   logic [NW-1:0] f_node_ff, f_node_in;
   logic [SymW-1:0] f_sym_ff, f_sym_in;
   logic [DepthW-1:0] d_ff, d_in;
   logic [NW:0]   i_ff, i_in;
   logic [NW-1:0] res_node_ff, res_node_in;
   logic [MatchW-1:0] res_id_ff, res_id_in;
   status_type    res_st_ff, res_st_in;
   logic          res_ram_ff, res_ram_in;
   logic          rsp_valid_ff, rsp_valid_in;
   logic [OutNodeW-1:0] rsp_node_ff, rsp_node_in;
   logic [MatchW-1:0] rsp_id_ff, rsp_id_in;
   status_type    rsp_st_ff, rsp_st_in;

   // goto table port
   logic           ch_we, ch_re;
   logic [CAW-1:0] ch_waddr, ch_raddr;
   logic [NW-1:0]  ch_wdata, ch_rd;

   // per-node tables share one write and one read address
   logic [NW-1:0] nd_waddr, nd_raddr;
   logic sym_we, par_we, dep_we, pat_we, fail_we;
   logic sym_re, par_re, dep_re, pat_re, fail_re;
   logic [SymW-1:0]   sym_wd, sym_rd;
   logic [NW-1:0]     par_wd, par_rd;
   logic [DepthW-1:0] dep_wd, dep_rd;
   logic [MatchW-1:0] pat_wd, pat_rd;
   logic [NW-1:0]     fail_wd, fail_rd;

   logic [SymW-1:0]   sym_mem  [NODES];
   logic [NW-1:0]     par_mem  [NODES];
   logic [DepthW-1:0] dep_mem  [NODES];
   logic [MatchW-1:0] pat_mem  [NODES];
   logic [NW-1:0]     fail_mem [NODES];

   logic [DepthW:0]   dep_next;
   logic [MatchW-1:0] new_id;
   logic              can_emit;

   acm_child_ram #(.AW(CAW), .DW(NW)) u_child (
      .clock (clock),
      .we    (ch_we),
      .waddr (ch_waddr),
      .wdata (ch_wdata),
      .re    (ch_re),
      .raddr (ch_raddr),
      .rdata (ch_rd)
   );

   always_ff @(posedge clock) begin
      if (sym_we)  sym_mem[nd_waddr]  <= sym_wd;
      if (par_we)  par_mem[nd_waddr]  <= par_wd;
      if (dep_we)  dep_mem[nd_waddr]  <= dep_wd;
      if (pat_we)  pat_mem[nd_waddr]  <= pat_wd;
      if (fail_we) fail_mem[nd_waddr] <= fail_wd;
      if (sym_re)  sym_rd  <= sym_mem[nd_raddr];
      if (par_re)  par_rd  <= par_mem[nd_raddr];
      if (dep_re)  dep_rd  <= dep_mem[nd_raddr];
      if (pat_re)  pat_rd  <= pat_mem[nd_raddr];
      if (fail_re) fail_rd <= fail_mem[nd_raddr];
   end

   assign dep_next = {1'b0, dep_rd} + (DepthW+1)'(1);
   assign new_id   = MatchW'(pcount_ff + PW'(1));
   assign can_emit = !rsp_valid_ff || rsp_chan.ready;

   assign req_chan.ready      = (state_ff == S_IDLE);
   assign csr_chan.ready      = 1'b1;
   assign rsp_chan.valid      = rsp_valid_ff;
   assign rsp_chan.current_node = rsp_node_ff;
   assign rsp_chan.match_id   = rsp_id_ff;
   assign rsp_chan.status     = rsp_st_ff;

   always_comb begin
      state_in = state_ff;   clr_in = clr_ff;       nf_in = nf_ff;
      pcount_in = pcount_ff; cursor_in = cursor_ff; scan_in = scan_ff;
      strict_in = strict_ff; maxdep_in = maxdep_ff; act_in = act_ff;
      sym_in = sym_ff;       last_in = last_ff;     f_node_in = f_node_ff;
      f_sym_in = f_sym_ff;   d_in = d_ff;           i_in = i_ff;
      res_node_in = res_node_ff; res_id_in = res_id_ff;
      res_st_in = res_st_ff; res_ram_in = res_ram_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_chan.ready;
      rsp_node_in = rsp_node_ff; rsp_id_in = rsp_id_ff; rsp_st_in = rsp_st_ff;
      ch_we = 1'b0; ch_re = 1'b0; ch_waddr = '0; ch_raddr = '0; ch_wdata = '0;
      nd_waddr = '0; nd_raddr = '0;
      sym_we = 1'b0; par_we = 1'b0; dep_we = 1'b0; pat_we = 1'b0; fail_we = 1'b0;
      sym_re = 1'b0; par_re = 1'b0; dep_re = 1'b0; pat_re = 1'b0; fail_re = 1'b0;
      sym_wd = '0; par_wd = '0; dep_wd = '0; pat_wd = '0; fail_wd = '0;

      if (csr_chan.valid) strict_in = csr_chan.strict_mode;

      unique case (state_ff)
         S_CLEAR: begin
            ch_we = 1'b1;
            ch_waddr = clr_ff[CAW-1:0];
            nd_waddr = clr_ff[NW-1:0];
            sym_we = 1'b1; par_we = 1'b1; dep_we = 1'b1; pat_we = 1'b1; fail_we = 1'b1;
            clr_in = clr_ff + (CAW+1)'(1);
            if (clr_ff == CLR_LAST) state_in = S_IDLE;
         end
         S_IDLE: begin
            if (req_chan.valid) begin
               act_in  = action_type'(req_chan.action);
               sym_in  = req_chan.data_byte;
               last_in = req_chan.last_byte;
               res_ram_in = 1'b0;
               res_id_in  = '0;
               res_st_in  = ST_OK;
               unique case (action_type'(req_chan.action))
                  ACT_ADD: begin
                     if (req_chan.last_byte && pcount_ff >= PAT_TOP) begin
                        res_node_in = cursor_ff;
                        res_st_in   = ST_PAT_FULL;
                        state_in    = S_OUT;
                     end else begin
                        ch_re = 1'b1;
                        ch_raddr = {cursor_ff, req_chan.data_byte};
                        dep_re = 1'b1;
                        nd_raddr = cursor_ff;
                        state_in = S_ADD_CHK;
                     end
                  end
                  ACT_BUILD: begin
                     d_in = DepthW'(1);
                     i_in = (NW+1)'(1);
                     state_in = S_B_NODE;
                  end
                  ACT_SCAN: begin
                     ch_re = 1'b1;
                     ch_raddr = {scan_ff, req_chan.data_byte};
                     f_node_in = scan_ff;
                     f_sym_in  = req_chan.data_byte;
                     state_in  = S_F_CHK;
                  end
                  ACT_RESET_SCAN: begin
                     scan_in = '0;
                     res_node_in = '0;
                     state_in = S_OUT;
                  end
                  default: state_in = S_IDLE;
               endcase
            end
         end
         S_ADD_CHK: begin
            res_st_in = ST_OK;
            if (ch_rd == '0) begin
               if (nf_ff >= NODE_TOP || dep_next > DEP_TOP) begin
                  res_node_in = cursor_ff;
                  res_st_in   = ST_NODE_FULL;
               end else begin
                  // new node: link it and fill its per-node entries
                  ch_we = 1'b1;
                  ch_waddr = {cursor_ff, sym_ff};
                  ch_wdata = nf_ff[NW-1:0];
                  nd_waddr = nf_ff[NW-1:0];
                  sym_we = 1'b1; sym_wd = sym_ff;
                  par_we = 1'b1; par_wd = cursor_ff;
                  dep_we = 1'b1; dep_wd = dep_next[DepthW-1:0];
                  pat_we = 1'b1; pat_wd = last_ff ? new_id : '0;
                  fail_we = 1'b1;
                  nf_in = nf_ff + (NW+1)'(1);
                  if (dep_next[DepthW-1:0] > maxdep_ff) maxdep_in = dep_next[DepthW-1:0];
                  res_node_in = nf_ff[NW-1:0];
                  res_id_in   = last_ff ? new_id : '0;
                  if (last_ff) begin
                     pcount_in = pcount_ff + PW'(1);
                     cursor_in = '0;
                  end else begin
                     cursor_in = nf_ff[NW-1:0];
                  end
               end
            end else begin
               res_node_in = ch_rd;
               if (last_ff) begin
                  nd_waddr = ch_rd;
                  pat_we = 1'b1; pat_wd = new_id;
                  pcount_in = pcount_ff + PW'(1);
                  cursor_in = '0;
                  res_id_in = new_id;
               end else begin
                  nd_raddr = ch_rd;
                  pat_re = 1'b1;
                  cursor_in = ch_rd;
                  res_ram_in = 1'b1;
               end
            end
            state_in = S_OUT;
         end
         S_F_CHK: begin
            if (ch_rd != '0 || f_node_ff == '0) begin
               if (act_ff == ACT_SCAN) begin
                  scan_in = ch_rd;
                  nd_raddr = ch_rd;
                  pat_re = 1'b1;
                  res_node_in = ch_rd;
                  res_ram_in = 1'b1;
                  state_in = S_OUT;
               end else begin
                  nd_waddr = i_ff[NW-1:0];
                  fail_we = 1'b1; fail_wd = ch_rd;
                  i_in = i_ff + (NW+1)'(1);
                  state_in = S_B_NODE;
               end
            end else if (act_ff == ACT_SCAN && strict_ff) begin
               // strict: retry the byte from root
               ch_re = 1'b1;
               ch_raddr = {{NW{1'b0}}, f_sym_ff};
               f_node_in = '0;
            end else begin
               nd_raddr = f_node_ff;
               fail_re = 1'b1;
               state_in = S_F_FAIL;
            end
         end
         S_F_FAIL, S_B_PAR: begin
            ch_re = 1'b1;
            ch_raddr = {fail_rd, f_sym_ff};
            f_node_in = fail_rd;
            state_in = S_F_CHK;
         end
         S_B_NODE: begin
            if (i_ff >= nf_ff) begin
               if (d_ff >= maxdep_ff) begin
                  res_node_in = '0;
                  state_in = S_OUT;
               end else begin
                  d_in = d_ff + DepthW'(1);
                  i_in = (NW+1)'(1);
               end
            end else begin
               nd_raddr = i_ff[NW-1:0];
               dep_re = 1'b1; sym_re = 1'b1; par_re = 1'b1;
               state_in = S_B_CHK;
            end
         end
         S_B_CHK: begin
            if (dep_rd != d_ff) begin
               i_in = i_ff + (NW+1)'(1);
               state_in = S_B_NODE;
            end else if (d_ff == DepthW'(1)) begin
               nd_waddr = i_ff[NW-1:0];
               fail_we = 1'b1;
               i_in = i_ff + (NW+1)'(1);
               state_in = S_B_NODE;
            end else begin
               nd_raddr = par_rd;
               fail_re = 1'b1;
               f_sym_in = sym_rd;
               state_in = S_B_PAR;
            end
         end
         S_OUT: begin
            if (can_emit) begin
               rsp_valid_in = 1'b1;
               rsp_node_in  = OutNodeW'(res_node_ff);
               rsp_id_in    = res_ram_ff ? pat_rd : res_id_ff;
               rsp_st_in    = res_st_ff;
               state_in     = S_IDLE;
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_CLEAR;
         clr_ff       <= '0;
         nf_ff        <= (NW+1)'(1);
         pcount_ff    <= '0;
         cursor_ff    <= '0;
         scan_ff      <= '0;
         strict_ff    <= 1'b0;
         maxdep_ff    <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         clr_ff       <= clr_in;
         nf_ff        <= nf_in;
         pcount_ff    <= pcount_in;
         cursor_ff    <= cursor_in;
         scan_ff      <= scan_in;
         strict_ff    <= strict_in;
         maxdep_ff    <= maxdep_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      act_ff      <= act_in;
      sym_ff      <= sym_in;
      last_ff     <= last_in;
      f_node_ff   <= f_node_in;
      f_sym_ff    <= f_sym_in;
      d_ff        <= d_in;
      i_ff        <= i_in;
      res_node_ff <= res_node_in;
      res_id_ff   <= res_id_in;
      res_st_ff   <= res_st_in;
      res_ram_ff  <= res_ram_in;
      rsp_node_ff <= rsp_node_in;
      rsp_id_ff   <= rsp_id_in;
      rsp_st_ff   <= rsp_st_in;
   end

   a_nf_bound: assert property (@(posedge clock) disable iff (reset)
      nf_ff <= NODE_TOP && nf_ff != '0)
      else $error("node allocator out of range");

   a_cursor_alloc: assert property (@(posedge clock) disable iff (reset)
      state_ff != S_CLEAR |-> ((NW+1)'(cursor_ff) < nf_ff && (NW+1)'(scan_ff) < nf_ff))
      else $error("cursor or scan node beyond allocated nodes");

   a_no_rsp_in_clear: assert property (@(posedge clock) disable iff (reset)
      state_ff == S_CLEAR |-> !rsp_valid_ff)
      else $error("response during clearing pass");

endmodule

`default_nettype wire

### rtl/acm_child_ram.sv
// acm_child_ram: goto table, one write and one registered read per cycle
// depends on acm_pkg only by convention (no imported names needed)
`default_nettype none

module acm_child_ram import acm_pkg::*; #(
   parameter int unsigned AW = 18,
   parameter int unsigned DW = 10
) (
   input  wire logic          clock,
   input  wire logic          we,
   input  wire logic [AW-1:0] waddr,
   input  wire logic [DW-1:0] wdata,
   input  wire logic          re,
   input  wire logic [AW-1:0] raddr,
   output logic      [DW-1:0] rdata
);

   logic [DW-1:0] mem [2**AW];

   always_ff @(posedge clock) begin
      if (we) mem[waddr] <= wdata;
      if (re) rdata <= mem[raddr];
   end

endmodule

`default_nettype wire
